FILE: sv/pgf_pkg.sv
// ----------------------------------------------------------------------------
// pgf_pkg: shared types and constants for the palette gradient fill unit
// palette geometry, fixed-point widths, request codes, sequencer states and
// the request and result structs
// ----------------------------------------------------------------------------
`default_nettype none

package pgf_pkg;

    localparam int PALETTE_DEPTH = 32;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int PEN_W         = 5;
    localparam int COLOR_W       = 12;
    localparam int CHAN_W        = 4;
    localparam int NUM_CHAN      = 3;
    localparam int FRAC_BITS     = 8;
    localparam int DIVD_W        = CHAN_W + FRAC_BITS;
    localparam int DIV_STEPS     = DIVD_W;
    localparam int CNT_W         = $clog2(DIV_STEPS + 1);
    localparam int STEP_W        = DIVD_W + 1;
    localparam int ACC_W         = DIVD_W + 2;
    localparam int CH_W          = $clog2(NUM_CHAN);

    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(128);

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_RAMP  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_RD_LO,
        ST_RD_HI,
        ST_DIV,
        ST_FILL
    } state_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [PEN_W-1:0]   pen_a;
        logic [PEN_W-1:0]   pen_b;
        logic [COLOR_W-1:0] color_in;
    } cmd_t;

    typedef struct packed {
        logic [PEN_W-1:0]   pen_out;
        logic [COLOR_W-1:0] color_out;
        logic               last_of_run;
    } res_t;

endpackage

`default_nettype wire

FILE: sv/palette_gradient_fill_unit.sv
// ----------------------------------------------------------------------------
// palette_gradient_fill_unit: 32-entry 12-bit palette with linear ramp fill
// write, read and ramp requests; a ramp runs one shared restoring divider
// over the three channels, then writes one inner pen per cycle
// ----------------------------------------------------------------------------
// a write is stored at the accepting edge; a read registers the entry, then the result in ST_READ
// ramp: endpoint reads in ST_RD_LO and ST_RD_HI, the divider in ST_DIV (each channel in
//   turn on the one shared divider), then one result per inner pen per cycle in ST_FILL
// busy stays high while a read or ramp runs and is already low when its last result is strobed
// results are strobed for one cycle and the receiver cannot stall them
// reset is asynchronous, active low; palette contents are undefined until written
`default_nettype none

module palette_gradient_fill_unit
    import pgf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire cmd_t cmd,
    output logic      strobe,
    output res_t      res
);

    // sequencer and control state
    state_t                 state_reg, state_next;
    logic [CH_W-1:0]        ch_reg, ch_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   strobe_reg, strobe_next;

    // payload registers
    res_t                   res_reg, res_next;
    logic [PEN_W-1:0]       lo_reg, lo_next;
    logic [PEN_W-1:0]       hi_reg, hi_next;
    logic [PEN_W-1:0]       pen_reg, pen_next;
    logic                   oob_reg, oob_next;
    logic [COLOR_W-1:0]     lo_rgb_reg, lo_rgb_next;
    logic [COLOR_W-1:0]     hi_rgb_reg, hi_rgb_next;
    logic [DIVD_W-1:0]      quo_reg, quo_next;
    logic [PEN_W-1:0]       rem_reg, rem_next;
    logic                   neg_reg, neg_next;
    logic signed [STEP_W-1:0] step_reg [NUM_CHAN];
    logic signed [STEP_W-1:0] step_next [NUM_CHAN];
    logic signed [ACC_W-1:0]  acc_reg [NUM_CHAN];
    logic signed [ACC_W-1:0]  acc_next [NUM_CHAN];

    // palette memory ports
    logic [COLOR_W-1:0]     pal_mem [PALETTE_DEPTH];
    logic [COLOR_W-1:0]     rd_data_reg;
    logic                   mem_we;
    logic [PAL_AW-1:0]      mem_waddr;
    logic [COLOR_W-1:0]     mem_wdata;
    logic [PAL_AW-1:0]      mem_raddr;

    // request decode
    logic                   accept;
    logic [PEN_W-1:0]       req_lo, req_hi;
    logic                   ramp_ok;
    logic                   pen_a_ok;

    // divider datapath
    logic [PEN_W-1:0]       span;
    logic [CHAN_W-1:0]      lo_ch, hi_ch;
    logic signed [CHAN_W:0] diff;
    logic [CHAN_W-1:0]      mag;
    logic [PEN_W:0]         rem_sh;
    logic                   q_bit;
    logic [DIVD_W-1:0]      quo_step;
    logic [PEN_W-1:0]       rem_step;
    logic signed [STEP_W-1:0] step_val;

    // fill datapath
    logic signed [ACC_W-1:0] acc_sum [NUM_CHAN];
    logic [COLOR_W-1:0]     fill_color;
    logic                   fill_last;

    assign accept   = start && !busy;
    assign req_lo   = (cmd.pen_a < cmd.pen_b) ? cmd.pen_a : cmd.pen_b;
    assign req_hi   = (cmd.pen_a < cmd.pen_b) ? cmd.pen_b : cmd.pen_a;
    assign pen_a_ok = 32'(cmd.pen_a) < PALETTE_DEPTH;
    // both ends on the palette and at least one pen strictly between
    assign ramp_ok  = (32'(req_hi) < PALETTE_DEPTH) && (PEN_W'(req_hi - req_lo) > PEN_W'(1));

    // one channel at a time through the divider: |hi - lo| << 8 over span
    assign span   = PEN_W'(hi_reg - lo_reg);
    assign lo_ch  = lo_rgb_reg[CHAN_W*ch_reg +: CHAN_W];
    assign hi_ch  = hi_rgb_reg[CHAN_W*ch_reg +: CHAN_W];
    assign diff   = $signed({1'b0, hi_ch}) - $signed({1'b0, lo_ch});
    assign mag    = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];

    // restoring divide step: one quotient bit per cycle
    assign rem_sh   = {rem_reg, quo_reg[DIVD_W-1]};
    assign q_bit    = rem_sh >= {1'b0, span};
    assign rem_step = q_bit ? PEN_W'(rem_sh - {1'b0, span}) : rem_sh[PEN_W-1:0];
    assign quo_step = {quo_reg[DIVD_W-2:0], q_bit};
    // truncation toward zero: divide the magnitude, then restore the sign
    assign step_val = neg_reg ? -$signed({1'b0, quo_step}) : $signed({1'b0, quo_step});

    // acc holds step*(k-1) + 128; adding step gives this pen's rounded offset
    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            acc_sum[c] = acc_reg[c] + ACC_W'(step_reg[c]);
            fill_color[CHAN_W*c +: CHAN_W] = CHAN_W'(lo_rgb_reg[CHAN_W*c +: CHAN_W]
                                           + acc_sum[c][FRAC_BITS +: CHAN_W]);
        end
    end

    assign fill_last = PEN_W'(pen_reg + 1'b1) == hi_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.kind == KIND_READ)
                        state_next = ST_READ;
                    else if (cmd.kind == KIND_RAMP && ramp_ok)
                        state_next = ST_RD_LO;
                end
            end
            ST_READ:  state_next = ST_IDLE;
            ST_RD_LO: state_next = ST_RD_HI;
            ST_RD_HI: state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS) && ch_reg == CH_W'(NUM_CHAN - 1))
                    state_next = ST_FILL;
            end
            ST_FILL:
            begin
                if (fill_last)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs: memory ports and the result strobe
    always_comb
    begin
        mem_we      = 1'b0;
        mem_waddr   = PAL_AW'(cmd.pen_a);
        mem_wdata   = cmd.color_in;
        mem_raddr   = PAL_AW'(cmd.pen_a);
        strobe_next = 1'b0;
        res_next    = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                mem_we = accept && cmd.kind == KIND_WRITE && pen_a_ok;
                if (cmd.kind == KIND_RAMP)
                    mem_raddr = PAL_AW'(req_lo);
            end
            ST_READ:
            begin
                strobe_next          = 1'b1;
                res_next.pen_out     = pen_reg;
                res_next.color_out   = oob_reg ? '0 : rd_data_reg;
                res_next.last_of_run = 1'b1;
            end
            ST_RD_LO:
            begin
                mem_raddr = PAL_AW'(hi_reg);
            end
            ST_FILL:
            begin
                mem_we               = 1'b1;
                mem_waddr            = PAL_AW'(pen_reg);
                mem_wdata            = fill_color;
                strobe_next          = 1'b1;
                res_next.pen_out     = pen_reg;
                res_next.color_out   = fill_color;
                res_next.last_of_run = fill_last;
            end
            default:
            begin
            end
        endcase
    end

    // datapath and counters
    always_comb
    begin
        ch_next     = ch_reg;
        cnt_next    = cnt_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        pen_next    = pen_reg;
        oob_next    = oob_reg;
        lo_rgb_next = lo_rgb_reg;
        hi_rgb_next = hi_rgb_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        neg_next    = neg_reg;
        step_next   = step_reg;
        acc_next    = acc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.kind == KIND_RAMP)
                    begin
                        lo_next  = req_lo;
                        hi_next  = req_hi;
                        pen_next = PEN_W'(req_lo + 1'b1);
                    end
                    else
                    begin
                        pen_next = cmd.pen_a;
                        oob_next = !pen_a_ok;
                    end
                end
            end
            ST_RD_LO:
            begin
                lo_rgb_next = rd_data_reg;
            end
            ST_RD_HI:
            begin
                hi_rgb_next = rd_data_reg;
                ch_next     = '0;
                cnt_next    = '0;
                for (int c = 0; c < NUM_CHAN; c++)
                    acc_next[c] = ROUND_HALF;
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    // load dividend for this channel
                    quo_next = {mag, FRAC_BITS'(0)};
                    rem_next = '0;
                    neg_next = diff[CHAN_W];
                    cnt_next = CNT_W'(1);
                end
                else
                begin
                    quo_next = quo_step;
                    rem_next = rem_step;
                    if (cnt_reg == CNT_W'(DIV_STEPS))
                    begin
                        step_next[ch_reg] = step_val;
                        cnt_next          = '0;
                        ch_next           = CH_W'(ch_reg + 1'b1);
                    end
                    else
                    begin
                        cnt_next = CNT_W'(cnt_reg + 1'b1);
                    end
                end
            end
            ST_FILL:
            begin
                pen_next = PEN_W'(pen_reg + 1'b1);
                for (int c = 0; c < NUM_CHAN; c++)
                    acc_next[c] = acc_sum[c];
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ch_reg     <= '0;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ch_reg     <= ch_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        pen_reg    <= pen_next;
        oob_reg    <= oob_next;
        lo_rgb_reg <= lo_rgb_next;
        hi_rgb_reg <= hi_rgb_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        step_reg   <= step_next;
        acc_reg    <= acc_next;
    end

    // palette: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            pal_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= pal_mem[mem_raddr];
    end

    assign busy   = state_reg != ST_IDLE;
    assign strobe = strobe_reg;
    assign res    = res_reg;

    // a result only follows a read or fill cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> ($past(state_reg) == ST_READ || $past(state_reg) == ST_FILL))
        else $error("result strobe without read or fill");

    // fill never touches the ramp ends
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FILL |-> (pen_reg > lo_reg && pen_reg < hi_reg))
        else $error("fill pen outside ramp interior");

    // the last result of a request frees the unit
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && res.last_of_run) |-> !busy)
        else $error("busy after last result");

    // divider counter stays within one channel's steps
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> cnt_reg <= CNT_W'(DIV_STEPS))
        else $error("divider count overrun");

endmodule

`default_nettype wire
